### rtl/core/ipd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared types and fixed constants of the incremental PID drive with ramp.
// ----------------------------------------------------------------------------
package ipd_pkg;

   // fixed field widths
   localparam int GAIN_WIDTH      = 12;
   localparam int SCALE_WIDTH     = 16;
   localparam int FRAC_BITS       = 16;
   localparam int GS_WIDTH        = GAIN_WIDTH + SCALE_WIDTH;
   localparam int DIST_WIDTH      = 17;
   localparam int OFFSET_WIDTH    = 20;
   localparam int RATE_WIDTH      = 13;
   localparam int FF_WIDTH        = 26;
   localparam int NUM_TERMS       = 3;

   // constant divisors of the serial divider
   localparam int DIVISOR_WIDTH   = 7;
   localparam logic [DIVISOR_WIDTH-1:0] PID_DIVISOR = 7'd100;
   localparam logic [DIVISOR_WIDTH-1:0] FF_DIVISOR  = 7'd10;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 20;

   typedef enum logic [1:0] {
      OP_PID   = 2'd0,
      OP_RAMP  = 2'd1,
      OP_CLEAR = 2'd2
   } opcode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_PROP_GAIN    = 3'd0,
      REG_INTEG_GAIN   = 3'd1,
      REG_DERIV_GAIN   = 3'd2,
      REG_FF_COEFF     = 3'd3,
      REG_TOWARD_RATE  = 3'd4,
      REG_AWAY_RATE    = 3'd5,
      REG_MAGNET_SCALE = 3'd6,
      REG_ZERO_OFFSET  = 3'd7
   } csr_index_type;

   // status of a serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

### rtl/core/incremental_pid_drive_with_ramp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incremental_pid_drive_with_ramp
// Velocity-form PID speed loop with acceleration ramp for a voice-coil drive.
// ----------------------------------------------------------------------------
// One word is processed at a time. A PID word (opcode 0) runs eight passes of
// the bit-serial multiplier (gain times magnet scale, then error magnitude
// times that product, for P, I and D, and the same pair for the feedforward)
// and two passes of the bit-serial constant divider (by 100 and by 10). A ramp
// word (opcode 1) skips the PID terms; a clear-history word returns nothing.
// The multiplier retires one bit per cycle, so its width sets the rate. A
// finished drive value sits in an output register, so the next word is taken
// while the result waits on rsp_tready.
// ----------------------------------------------------------------------------
module incremental_pid_drive_with_ramp
   import ipd_pkg::*;
#(
   parameter int DRIVE_WIDTH = 20,
   parameter int ERROR_WIDTH = 18
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // speed_error, direction, travelled_distance
   input  logic [((ERROR_WIDTH+1+DIST_WIDTH+7)/8)*8-1:0] req_tdata,
   // opcode
   input  logic [1:0]                  req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // drive_out
   output logic [((DRIVE_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]   csr_data
);

   localparam int XW  = ERROR_WIDTH + 2;
   localparam int MW  = (XW > DIST_WIDTH) ? XW : DIST_WIDTH;
   localparam int PW  = MW + GS_WIDTH;
   localparam int QW  = PW - FRAC_BITS;
   localparam int SW  = QW + 3;
   localparam int NW  = QW + 2;
   localparam int TMW = (DRIVE_WIDTH - 1 > RATE_WIDTH) ? DRIVE_WIDTH - 1 : RATE_WIDTH;
   localparam int HW  = ((DRIVE_WIDTH > TMW + 1) ? DRIVE_WIDTH : TMW + 1) + 1;
   localparam int OW  = ((DRIVE_WIDTH > FF_WIDTH + 1) ? DRIVE_WIDTH : FF_WIDTH + 1) + 2;
   localparam int RSP_TW = ((DRIVE_WIDTH + 7) / 8) * 8;

   localparam logic signed [DRIVE_WIDTH-1:0] DMAX_D = {1'b0, {(DRIVE_WIDTH-1){1'b1}}};
   localparam logic signed [HW-1:0]          DMAX_H = HW'(DMAX_D);
   localparam logic signed [OW-1:0]          DMAX_O = OW'(DMAX_D);
   localparam logic [NW-1:0]                 DMAX_N = NW'(DMAX_D);

   typedef enum logic [9:0] {
      ST_IDLE = 10'b00_0000_0001,
      ST_GAIN = 10'b00_0000_0010,
      ST_ERR  = 10'b00_0000_0100,
      ST_DIV  = 10'b00_0000_1000,
      ST_HOLD = 10'b00_0001_0000,
      ST_FSCL = 10'b00_0010_0000,
      ST_FPOS = 10'b00_0100_0000,
      ST_FDIV = 10'b00_1000_0000,
      ST_OUT  = 10'b01_0000_0000,
      ST_WAIT = 10'b10_0000_0000
   } state_type;

   // sequencer and handshake
   state_type state_ff, state_in;
   logic      run_ff, run_in;
   logic [1:0] k_ff, k_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [DRIVE_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   // configuration registers
   logic [GAIN_WIDTH-1:0]   prop_ff, prop_in;
   logic [7:0]              integ_ff, integ_in;
   logic [9:0]              deriv_ff, deriv_in;
   logic [9:0]              coeff_ff, coeff_in;
   logic [RATE_WIDTH-1:0]   toward_ff, toward_in;
   logic [RATE_WIDTH-1:0]   away_ff, away_in;
   logic [SCALE_WIDTH-1:0]  scale_ff, scale_in;
   logic signed [OFFSET_WIDTH-1:0] offset_ff, offset_in;

   // loop state
   logic signed [ERROR_WIDTH-1:0] last_ff, last_in;
   logic signed [ERROR_WIDTH-1:0] prev_ff, prev_in;
   logic signed [DRIVE_WIDTH-1:0] held_ff, held_in;

   // working registers
   logic [XW-1:0]          xmag_ff [NUM_TERMS];
   logic [XW-1:0]          xmag_in [NUM_TERMS];
   logic                   xneg_ff [NUM_TERMS];
   logic                   xneg_in [NUM_TERMS];
   logic                   dir_ff, dir_in;
   logic [DIST_WIDTH-1:0]  dmag_ff, dmag_in;
   logic                   dneg_ff, dneg_in;
   logic [GS_WIDTH-1:0]    gs_ff, gs_in;
   logic signed [SW-1:0]   sum_ff, sum_in;
   logic [TMW-1:0]         tmag_ff, tmag_in;
   logic                   tneg_ff, tneg_in;
   logic [FF_WIDTH-1:0]    ffm_ff, ffm_in;
   logic [FF_WIDTH-1:0]    ffq_ff, ffq_in;

   // input fields
   logic signed [ERROR_WIDTH-1:0] in_err;
   logic                          in_dir;
   logic signed [DIST_WIDTH-1:0]  in_dist;

   // combinational helpers
   logic signed [XW-1:0]   e_x, last_x, prev_x, sub_x, dd_x;
   logic [GAIN_WIDTH-1:0]  gain_sel;
   logic [QW-1:0]          term_mag;
   logic signed [SW-1:0]   term_s;
   logic [SW-1:0]          sum_mag;
   logic signed [HW-1:0]   held_ext, tm_ext, held_sum;
   logic signed [DRIVE_WIDTH-1:0] held_new;
   logic signed [OW-1:0]   off_ext, ff_ext, hld_ext, out_sum;
   logic signed [DRIVE_WIDTH-1:0] out_new;
   logic                   out_load;

   // unit connections
   logic                   mul_state, div_state;
   logic                   mul_start, div_start;
   logic [MW-1:0]          mul_a;
   logic [GS_WIDTH-1:0]    mul_b;
   logic [PW-1:0]          mul_prod;
   unit_status_type        mul_sts;
   logic [NW-1:0]          div_n;
   logic [DIVISOR_WIDTH-1:0] div_d;
   logic [NW-1:0]          div_q;
   unit_status_type        div_sts;

   function automatic logic [XW-1:0] mag_x(input logic [XW-1:0] v);
      mag_x = v[XW-1] ? (~v + 1'b1) : v;
   endfunction

   assign in_err  = $signed(req_tdata[ERROR_WIDTH-1:0]);
   assign in_dir  = req_tdata[ERROR_WIDTH];
   assign in_dist = $signed(req_tdata[ERROR_WIDTH+1 +: DIST_WIDTH]);

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TW'(rsp_data_ff);

   // serial arithmetic units
   assign mul_state = (state_ff == ST_GAIN) || (state_ff == ST_ERR) ||
                      (state_ff == ST_FSCL) || (state_ff == ST_FPOS);
   assign div_state = (state_ff == ST_DIV) || (state_ff == ST_FDIV);
   assign mul_start = mul_state && !run_ff;
   assign div_start = div_state && !run_ff;

   ipd_mul #(
      .A_WIDTH (MW),
      .B_WIDTH (GS_WIDTH)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .status  (mul_sts),
      .product (mul_prod)
   );

   ipd_div #(
      .N_WIDTH (NW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .status   (div_sts),
      .quotient (div_q)
   );

   // operand selection
   always_comb begin
      case (k_ff)
         2'd0:    gain_sel = prop_ff;
         2'd1:    gain_sel = GAIN_WIDTH'(integ_ff);
         default: gain_sel = GAIN_WIDTH'(deriv_ff);
      endcase
      case (state_ff)
         ST_GAIN: begin
            mul_a = MW'(scale_ff);
            mul_b = GS_WIDTH'(gain_sel);
         end
         ST_ERR: begin
            mul_a = MW'(xmag_ff[0]);
            mul_b = gs_ff;
         end
         ST_FSCL: begin
            mul_a = MW'(scale_ff);
            mul_b = GS_WIDTH'(coeff_ff);
         end
         default: begin
            mul_a = MW'(dmag_ff);
            mul_b = gs_ff;
         end
      endcase
      sum_mag = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
      if (state_ff == ST_DIV) begin
         div_n = sum_mag[NW-1:0];
         div_d = PID_DIVISOR;
      end else begin
         div_n = NW'(ffm_ff);
         div_d = FF_DIVISOR;
      end
   end

   // error differences of a new PID word
   always_comb begin
      e_x    = XW'(in_err);
      last_x = XW'(last_ff);
      prev_x = XW'(prev_ff);
      sub_x  = e_x - last_x;
      dd_x   = e_x - (last_x <<< 1) + prev_x;
   end

   // scaled term and held drive update
   always_comb begin
      term_mag = mul_prod[PW-1:FRAC_BITS];
      term_s   = $signed(SW'(term_mag));
      held_ext = HW'(held_ff);
      tm_ext   = $signed(HW'(tmag_ff));
      held_sum = tneg_ff ? (held_ext - tm_ext) : (held_ext + tm_ext);
      if (held_sum > DMAX_H) begin
         held_new = DMAX_D;
      end else if (held_sum < -DMAX_H) begin
         held_new = -DMAX_D;
      end else begin
         held_new = held_sum[DRIVE_WIDTH-1:0];
      end
   end

   // drive output: offset plus feedforward plus held drive, clamped
   always_comb begin
      off_ext = OW'(offset_ff);
      ff_ext  = $signed(OW'(ffq_ff));
      hld_ext = OW'(held_ff);
      out_sum = off_ext + (dneg_ff ? -ff_ext : ff_ext) + hld_ext;
      if (out_sum > DMAX_O) begin
         out_new = DMAX_D;
      end else if (out_sum < -DMAX_O) begin
         out_new = -DMAX_D;
      end else begin
         out_new = out_sum[DRIVE_WIDTH-1:0];
      end
      out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      run_in       = run_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      prop_in      = prop_ff;
      integ_in     = integ_ff;
      deriv_in     = deriv_ff;
      coeff_in     = coeff_ff;
      toward_in    = toward_ff;
      away_in      = away_ff;
      scale_in     = scale_ff;
      offset_in    = offset_ff;
      last_in      = last_ff;
      prev_in      = prev_ff;
      held_in      = held_ff;
      xmag_in      = xmag_ff;
      xneg_in      = xneg_ff;
      dir_in       = dir_ff;
      dmag_in      = dmag_ff;
      dneg_in      = dneg_ff;
      gs_in        = gs_ff;
      sum_in       = sum_ff;
      tmag_in      = tmag_ff;
      tneg_in      = tneg_ff;
      ffm_in       = ffm_ff;
      ffq_in       = ffq_ff;

      // register writes
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_PROP_GAIN:    prop_in   = csr_data[GAIN_WIDTH-1:0];
            REG_INTEG_GAIN:   integ_in  = csr_data[7:0];
            REG_DERIV_GAIN:   deriv_in  = csr_data[9:0];
            REG_FF_COEFF:     coeff_in  = csr_data[9:0];
            REG_TOWARD_RATE:  toward_in = csr_data[RATE_WIDTH-1:0];
            REG_AWAY_RATE:    away_in   = csr_data[RATE_WIDTH-1:0];
            REG_MAGNET_SCALE: scale_in  = csr_data[SCALE_WIDTH-1:0];
            REG_ZERO_OFFSET:  offset_in = $signed(csr_data[OFFSET_WIDTH-1:0]);
         endcase
      end

      // unit run flag
      if (mul_start || div_start) begin
         run_in = 1'b1;
      end
      if (mul_sts.done || div_sts.done) begin
         run_in = 1'b0;
      end

      // output register
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = out_new;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               dir_in  = in_dir;
               dneg_in = in_dist[DIST_WIDTH-1];
               dmag_in = in_dist[DIST_WIDTH-1] ? DIST_WIDTH'(-in_dist)
                                               : DIST_WIDTH'(in_dist);
               unique case (req_tuser)
                  OP_PID: begin
                     xmag_in[0] = mag_x(sub_x);
                     xneg_in[0] = sub_x[XW-1];
                     xmag_in[1] = mag_x(e_x);
                     xneg_in[1] = e_x[XW-1];
                     xmag_in[2] = mag_x(dd_x);
                     xneg_in[2] = dd_x[XW-1];
                     prev_in    = last_ff;
                     last_in    = in_err;
                     sum_in     = '0;
                     k_in       = '0;
                     state_in   = ST_GAIN;
                  end
                  OP_RAMP: begin
                     tmag_in  = in_dir ? TMW'(away_ff) : TMW'(toward_ff);
                     tneg_in  = in_dir;
                     state_in = ST_HOLD;
                  end
                  OP_CLEAR: begin
                     last_in = '0;
                     prev_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_GAIN: begin
            if (mul_sts.done) begin
               gs_in    = mul_prod[GS_WIDTH-1:0];
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            if (mul_sts.done) begin
               sum_in     = sum_ff + (xneg_ff[0] ? -term_s : term_s);
               xmag_in[0] = xmag_ff[1];
               xneg_in[0] = xneg_ff[1];
               xmag_in[1] = xmag_ff[2];
               xneg_in[1] = xneg_ff[2];
               if (k_ff == 2'(NUM_TERMS - 1)) begin
                  state_in = ST_DIV;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_GAIN;
               end
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               tmag_in  = (div_q > DMAX_N) ? TMW'(DMAX_D) : div_q[TMW-1:0];
               tneg_in  = dir_ff ^ sum_ff[SW-1];
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            held_in  = held_new;
            state_in = ST_FSCL;
         end
         ST_FSCL: begin
            if (mul_sts.done) begin
               gs_in    = mul_prod[GS_WIDTH-1:0];
               state_in = ST_FPOS;
            end
         end
         ST_FPOS: begin
            if (mul_sts.done) begin
               ffm_in   = mul_prod[FRAC_BITS +: FF_WIDTH];
               state_in = ST_FDIV;
            end
         end
         ST_FDIV: begin
            if (div_sts.done) begin
               ffq_in   = div_q[FF_WIDTH-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control and configuration state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_ff       <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         prop_ff      <= GAIN_WIDTH'(2000);
         integ_ff     <= 8'd100;
         deriv_ff     <= 10'd200;
         coeff_ff     <= 10'd260;
         toward_ff    <= RATE_WIDTH'(100);
         away_ff      <= RATE_WIDTH'(100);
         scale_ff     <= SCALE_WIDTH'(24904);
         offset_ff    <= '0;
         last_ff      <= '0;
         prev_ff      <= '0;
         held_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         run_ff       <= run_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         prop_ff      <= prop_in;
         integ_ff     <= integ_in;
         deriv_ff     <= deriv_in;
         coeff_ff     <= coeff_in;
         toward_ff    <= toward_in;
         away_ff      <= away_in;
         scale_ff     <= scale_in;
         offset_ff    <= offset_in;
         last_ff      <= last_in;
         prev_ff      <= prev_in;
         held_ff      <= held_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      xmag_ff     <= xmag_in;
      xneg_ff     <= xneg_in;
      dir_ff      <= dir_in;
      dmag_ff     <= dmag_in;
      dneg_ff     <= dneg_in;
      gs_ff       <= gs_in;
      sum_ff      <= sum_in;
      tmag_ff     <= tmag_in;
      tneg_ff     <= tneg_in;
      ffm_ff      <= ffm_in;
      ffq_ff      <= ffq_in;
   end

   // held drive never leaves the clamp range
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      (held_ff <= DMAX_D) && (held_ff >= -DMAX_D))
      else $error("held drive out of range");

   // a delivered drive word is always clamped
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (($signed(rsp_data_ff) <= DMAX_D) && ($signed(rsp_data_ff) >= -DMAX_D)))
      else $error("drive word out of range");

   // a serial unit is never restarted while it runs
   a_unit_free: assert property (@(posedge clock) disable iff (reset)
      (mul_start |-> !mul_sts.busy) and (div_start |-> !div_sts.busy))
      else $error("serial unit restarted while busy");

   // a PID word shifts the error history
   a_history: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == OP_PID))
      |=> ((last_ff == $past(in_err)) && (prev_ff == $past(last_ff))))
      else $error("error history not shifted");

   // a clear word zeroes the error history
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == OP_CLEAR))
      |=> ((last_ff == '0) && (prev_ff == '0)))
      else $error("error history not cleared");

endmodule

### rtl/core/ipd_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ipd_mul
   import ipd_pkg::*;
#(
   parameter int A_WIDTH = 20,
   parameter int B_WIDTH = 28
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [A_WIDTH-1:0]          a,
   input  logic [B_WIDTH-1:0]          b,
   output unit_status_type             status,
   output logic [A_WIDTH+B_WIDTH-1:0]  product
);

   localparam int P_WIDTH = A_WIDTH + B_WIDTH;
   localparam int CW      = $clog2(A_WIDTH + 1);

   logic [P_WIDTH-1:0] acc_ff, acc_in;
   logic [A_WIDTH-1:0] mplr_ff, mplr_in;
   logic [B_WIDTH-1:0] mcand_ff, mcand_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [B_WIDTH:0]   partial;

   // add the multiplicand into the upper half when the multiplier bit is set, then shift right one bit
   always_comb begin
      partial  = {1'b0, acc_ff[P_WIDTH-1:A_WIDTH]}
               + (mplr_ff[0] ? {1'b0, mcand_ff} : '0);
      acc_in   = acc_ff;
      mplr_in  = mplr_ff;
      mcand_in = mcand_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         acc_in   = '0;
         mplr_in  = a;
         mcand_in = b;
         cnt_in   = CW'(A_WIDTH);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in  = {partial, acc_ff[A_WIDTH-1:1]};
         mplr_in = mplr_ff >> 1;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mplr_ff  <= mplr_in;
      mcand_ff <= mcand_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = acc_ff;

endmodule

### rtl/core/ipd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_div
// Bit-serial restoring divider by a small constant, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ipd_div
   import ipd_pkg::*;
#(
   parameter int N_WIDTH = 34
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [N_WIDTH-1:0]        dividend,
   input  logic [DIVISOR_WIDTH-1:0]  divisor,
   output unit_status_type           status,
   output logic [N_WIDTH-1:0]        quotient
);

   localparam int CW = $clog2(N_WIDTH + 1);

   logic [N_WIDTH-1:0]       quo_ff, quo_in;
   logic [DIVISOR_WIDTH-1:0] rem_ff, rem_in;
   logic [DIVISOR_WIDTH-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIVISOR_WIDTH:0]   trial;
   logic [DIVISOR_WIDTH:0]   diff;
   logic                     fits;

   // bring down the next dividend bit, subtract when the divisor fits
   always_comb begin
      trial  = {rem_ff, quo_ff[N_WIDTH-1]};
      diff   = trial - {1'b0, dvs_ff};
      fits   = (trial >= {1'b0, dvs_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(N_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[N_WIDTH-2:0], fits};
         rem_in = fits ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule
